FILE: design/bls_pkg.sv
// Shared constants, command codes and beat types for the Bresenham line stepper.
`timescale 1ns / 1ps
`default_nettype none
package bls_pkg;

  // Coordinate width of the grid and width of the signed error term
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 2;

  // Command codes
  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } bls_cmd_t;

  // Request beat
  typedef struct packed {
    bls_cmd_t              command;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic                  check_mode;
    logic                  cell_blocked;
  } bls_req_t;

  // Response beat
  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic                  point_valid;
    logic                  point_last;
    logic                  verdict_valid;
    logic                  line_clear;
  } bls_rsp_t;

endpackage
`default_nettype wire

FILE: design/bls_walker.sv
// Line walker: holds the Bresenham state and computes one line step per beat.
`timescale 1ns / 1ps
`default_nettype none
module bls_walker
  import bls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     take,
  input  wire bls_req_t req,
  output bls_rsp_t      rsp
);

  // Line state
  logic [COORD_BITS-1:0]      current_x, current_y, target_x, target_y;
  logic [COORD_BITS-1:0]      delta_x, delta_y;
  logic                       step_x_negative, step_y_negative;
  logic signed [ERR_BITS-1:0] error_term;
  logic                       checking, line_active, at_end;

  logic [COORD_BITS-1:0]      current_x_next, current_y_next, target_x_next, target_y_next;
  logic [COORD_BITS-1:0]      delta_x_next, delta_y_next;
  logic                       step_x_negative_next, step_y_negative_next;
  logic signed [ERR_BITS-1:0] error_term_next;
  logic                       checking_next, line_active_next, at_end_next;

  // Step arithmetic
  logic [COORD_BITS-1:0]      abs_dx, abs_dy, nx, ny;
  logic                       start_end;
  logic signed [ERR_BITS:0]   e2, dx_w, ndy_w;
  logic                       x_go, y_go;
  logic signed [ERR_BITS-1:0] err_sub, err_add;

  // Compute next state and the response for the offered beat
  always_comb begin
    current_x_next       = current_x;
    current_y_next       = current_y;
    target_x_next        = target_x;
    target_y_next        = target_y;
    delta_x_next         = delta_x;
    delta_y_next         = delta_y;
    step_x_negative_next = step_x_negative;
    step_y_negative_next = step_y_negative;
    error_term_next      = error_term;
    checking_next        = checking;
    line_active_next     = line_active;
    at_end_next          = at_end;
    rsp                  = '0;

    abs_dx    = (req.end_x > req.start_x) ? req.end_x - req.start_x : req.start_x - req.end_x;
    abs_dy    = (req.end_y > req.start_y) ? req.end_y - req.start_y : req.start_y - req.end_y;
    start_end = (req.start_x == req.end_x) && (req.start_y == req.end_y);

    // Doubled error compared against -dy and dx
    e2    = {error_term, 1'b0};
    dx_w  = $signed({3'b000, delta_x});
    ndy_w = -$signed({3'b000, delta_y});
    x_go  = e2 > ndy_w;
    nx    = x_go ? (step_x_negative ? current_x - 1'b1 : current_x + 1'b1) : current_x;
    y_go  = !((nx == target_x) && (current_y == target_y)) && (e2 < dx_w);
    ny    = y_go ? (step_y_negative ? current_y - 1'b1 : current_y + 1'b1) : current_y;
    err_sub = x_go ? $signed({2'b00, delta_y}) : '0;
    err_add = y_go ? $signed({2'b00, delta_x}) : '0;

    if (req.command == CMD_START) begin
      // Load a new line and emit its start point
      current_x_next       = req.start_x;
      current_y_next       = req.start_y;
      target_x_next        = req.end_x;
      target_y_next        = req.end_y;
      delta_x_next         = abs_dx;
      delta_y_next         = abs_dy;
      step_x_negative_next = !(req.start_x < req.end_x);
      step_y_negative_next = !(req.start_y < req.end_y);
      error_term_next      = $signed({2'b00, abs_dx}) - $signed({2'b00, abs_dy});
      checking_next        = req.check_mode;
      at_end_next          = start_end;
      line_active_next     = req.check_mode || !start_end;
      rsp.point_x          = req.start_x;
      rsp.point_y          = req.start_y;
      rsp.point_valid      = 1'b1;
      rsp.point_last       = start_end;
    end else if (!line_active) begin
      // Advance while idle: empty beat
      rsp = '0;
    end else if (checking && (req.cell_blocked || at_end)) begin
      // Finish the check with a verdict
      line_active_next  = 1'b0;
      rsp.verdict_valid = 1'b1;
      rsp.line_clear    = !req.cell_blocked;
    end else begin
      // Take one step along the line
      current_x_next   = nx;
      current_y_next   = ny;
      error_term_next  = error_term - err_sub + err_add;
      at_end_next      = (nx == target_x) && (ny == target_y);
      if (!checking && at_end_next) begin
        line_active_next = 1'b0;
      end
      rsp.point_x      = nx;
      rsp.point_y      = ny;
      rsp.point_valid  = 1'b1;
      rsp.point_last   = at_end_next;
    end
  end

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      current_x       <= '0;
      current_y       <= '0;
      target_x        <= '0;
      target_y        <= '0;
      delta_x         <= '0;
      delta_y         <= '0;
      step_x_negative <= 1'b0;
      step_y_negative <= 1'b0;
      error_term      <= '0;
      checking        <= 1'b0;
      line_active     <= 1'b0;
      at_end          <= 1'b0;
    end else if (take) begin
      current_x       <= current_x_next;
      current_y       <= current_y_next;
      target_x        <= target_x_next;
      target_y        <= target_y_next;
      delta_x         <= delta_x_next;
      delta_y         <= delta_y_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      error_term      <= error_term_next;
      checking        <= checking_next;
      line_active     <= line_active_next;
      at_end          <= at_end_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/bls_out_reg.sv
// Output register: holds one response beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module bls_out_reg
  import bls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     load,
  input  wire bls_rsp_t din,
  output logic          can_load,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output bls_rsp_t      rsp
);

  // Accept a new beat when empty or draining this cycle
  assign can_load = !rsp_valid || rsp_ready;

  // Hold valid until the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= din;
    end
  end

endmodule
`default_nettype wire

FILE: design/bresenham_line_stepper_core.sv
// Top level of the Bresenham line stepper: walker plus output register.
`timescale 1ns / 1ps
`default_nettype none
// The stepper takes one command beat per clock and returns exactly one
// response beat for each, in the cycle after acceptance. A start beat loads the
// endpoints and mode and returns the start point; each advance beat returns
// the next line point, or in check mode the verdict once a blocked point or
// the end is reached; an advance while idle returns an all-zero beat. The
// whole step (one doubled-error compare against -dy and dx, one add to the
// error, one step per axis) sits between the line state registers and
// the output register, so the sustained rate is one beat per cycle; req_ready
// falls only while a finished beat waits in the output register and
// rsp_ready is low.
module bresenham_line_stepper_core
  import bls_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire bls_req_t req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output bls_rsp_t      rsp
);

  logic     take;
  bls_rsp_t step_rsp;

  assign take = req_valid && req_ready;

  bls_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .req  (req),
    .rsp  (step_rsp)
  );

  bls_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .din       (step_rsp),
    .can_load  (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // A start beat always yields a point in the next response
  a_start_point: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.command == CMD_START) |=> rsp_valid && rsp.point_valid)
    else $error("start beat did not produce a point");

  // A response never carries both a point and a verdict
  a_point_or_verdict: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.point_valid && rsp.verdict_valid))
    else $error("point and verdict in one beat");

  // Last marks only a real point; clear only a real verdict
  a_flag_qualified: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (!rsp.point_last || rsp.point_valid) && (!rsp.line_clear || rsp.verdict_valid))
    else $error("flag set without its qualifier");
`endif

endmodule
`default_nettype wire
